// ----- rtl/usrs_pkg.sv -----
// ============================================================================
// usrs_pkg: shared types and constants for the UTF-8 safe row splitter
// Holds the request and result payload types, the configuration register
// set, register indexes, UTF-8 byte classes and result queue sizing.
// ============================================================================
package usrs_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 64;
    localparam int LEN_W  = 9;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd2;

    // UTF-8 byte classes
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hc2;
    localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hf4;

    // Lookback window: the current byte plus three before it
    localparam int LB_DEPTH = 3;
    localparam int SEQ_W    = 3;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              chunk_end;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] row_offset;
        logic [LEN_W-1:0]  row_length;
        logic              last_row;
        logic              status;
        logic [ADDR_W-1:0] next_offset;
    } out_item_t;

    typedef struct packed {
        logic              hex_mode;
        logic [ADDR_W-1:0] chunk_offset;
        logic [ADDR_W-1:0] total_length;
    } cfg_t;

    // Result pushes from the split logic into the queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Sequence length announced by a lead byte, 1 for anything else
    function automatic logic [SEQ_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [SEQ_W-1:0] n;
        n = 3'd1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) n = 3'd2;
        if (b >= LEAD3_LO && b <= LEAD3_HI) n = 3'd3;
        if (b >= LEAD4_LO && b <= LEAD4_HI) n = 3'd4;
        return n;
    endfunction

endpackage

// ----- rtl/utf8_safe_row_splitter_top.sv -----
// ============================================================================
// utf8_safe_row_splitter_top: UTF-8 safe row splitter
// Cuts a chunk, one byte per request, into hex or UTF-8 safe text rows and
// reports each row's absolute offset and length.
// ============================================================================
// The block takes one byte per cycle unless the input stalls. An accepted
// byte goes through the input register into the split logic, whose results
// are registered in the four-entry result queue. Most bytes produce no row
// or one row; the final byte of a text chunk can produce two, which the
// queue hands out one at a time. The input stalls while the queue holds more
// than two results, so with no output stalls the block sustains one
// byte per cycle. In text mode a row is cut once the byte after it arrives
// and released three bytes later or at chunk end, because a dropped
// incomplete tail can still shorten it. A chunk that is too long or runs
// past total_length ends with one result with status 1; rows already sent
// for that chunk must be discarded by the user. Write configuration only
// while the block is idle; hex_mode is sampled at a chunk's first byte.
// ============================================================================
module utf8_safe_row_splitter_top #(
    parameter int MAX_CHUNK      = 65536,
    parameter int TEXT_ROW_WIDTH = 256,
    parameter int HEX_ROW_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  usrs_pkg::in_item_t                in_data,
    // row results
    output logic                              out_valid,
    input  logic                              out_stall,
    output usrs_pkg::out_item_t               out_data,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [usrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [usrs_pkg::ADDR_W-1:0]       cfg_data
);

    usrs_pkg::cfg_t      cfg;
    usrs_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    logic                space;
    logic                fire;
    usrs_pkg::push_t     push;
    usrs_pkg::out_item_t res0;
    usrs_pkg::out_item_t res1;

    // Configuration is always writable
    assign cfg_ready = 1'b1;

    usrs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Hold the input register while the queue lacks room for two results
    assign fire     = in_valid_reg && space;
    assign in_stall = in_valid_reg && !space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Advance the byte payload on every accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    usrs_core #(
        .MAX_CHUNK      (MAX_CHUNK),
        .TEXT_ROW_WIDTH (TEXT_ROW_WIDTH),
        .HEX_ROW_WIDTH  (HEX_ROW_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .push  (push),
        .res0  (res0),
        .res1  (res1)
    );

    usrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/usrs_cfg.sv -----
// ============================================================================
// usrs_cfg: configuration register file
// Holds hex_mode, chunk_offset and total_length; writes to unused indexes
// are dropped.
// ============================================================================
module usrs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [usrs_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [usrs_pkg::ADDR_W-1:0]        wr_data,
    output usrs_pkg::cfg_t                     cfg
);

    usrs_pkg::cfg_t cfg_reg;
    usrs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                usrs_pkg::CFG_HEX_MODE:     cfg_next.hex_mode     = wr_data[0];
                usrs_pkg::CFG_CHUNK_OFFSET: cfg_next.chunk_offset = wr_data;
                usrs_pkg::CFG_TOTAL_LENGTH: cfg_next.total_length = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/usrs_core.sv -----
// ============================================================================
// usrs_core: row split logic
// Processes one byte per fire: tracks chunk position, row start, pending
// text cut and reject flag, and forms up to two result rows.
// ============================================================================
module usrs_core #(
    parameter int MAX_CHUNK      = 65536,
    parameter int TEXT_ROW_WIDTH = 256,
    parameter int HEX_ROW_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  usrs_pkg::in_item_t    item,
    input  usrs_pkg::cfg_t        cfg,
    output usrs_pkg::push_t       push,
    output usrs_pkg::out_item_t   res0,
    output usrs_pkg::out_item_t   res1
);

    localparam int POS_W = $clog2(MAX_CHUNK + 1);
    localparam int TXT_W = $clog2(TEXT_ROW_WIDTH + 1);
    localparam int HEX_W = $clog2(HEX_ROW_WIDTH + 1);
    localparam int MW1   = (POS_W > TXT_W) ? POS_W : TXT_W;
    localparam int CW    = ((MW1 > HEX_W) ? MW1 : HEX_W) + 1;
    localparam int AW    = usrs_pkg::ADDR_W;
    localparam int LW    = usrs_pkg::LEN_W;

    // control state
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] rb_reg;
    logic             rej_reg;
    logic             hex_reg;
    logic             pv_reg;
    // pending row and lookback payload
    logic [POS_W-1:0] pb_reg;
    logic [POS_W-1:0] pc_reg;
    logic [POS_W-1:0] pn_reg;
    logic [usrs_pkg::BYTE_W-1:0] lb_reg [0:usrs_pkg::LB_DEPTH-1];

    logic [usrs_pkg::BYTE_W-1:0] lb_new [0:usrs_pkg::LB_DEPTH];
    logic [usrs_pkg::LB_DEPTH:0] cont;
    logic [usrs_pkg::SEQ_W-1:0]  lead [0:usrs_pkg::LB_DEPTH];

    logic [CW-1:0]    idx_c;
    logic             fin;
    logic             hex_next;
    logic             rej_next;
    logic             emit_pend;
    logic             pv_mid;
    logic             set_pend;
    logic             hex_emit;
    logic [1:0]       kc;
    logic [POS_W-1:0] cut;
    logic             pv_next;
    logic [POS_W-1:0] pb_next;
    logic [POS_W-1:0] pc_next;
    logic [POS_W-1:0] pn_next;
    logic [POS_W-1:0] rb_next;
    logic [POS_W-1:0] pos_next;

    logic [AW-1:0]    size;
    logic             bad;
    logic             tail_open;
    logic             c0;
    logic             c1;
    logic             c2;
    logic [1:0]       k2;
    logic             skip3;
    logic             trim;
    logic [POS_W-1:0] kept;
    logic             split_two;

    logic [POS_W-1:0] base0;
    logic [POS_W-1:0] len0;
    logic             last0;
    logic [AW-1:0]    next_off;

    always_comb
    begin
        lb_new[0] = item.data_byte;
        for (int j = 1; j <= usrs_pkg::LB_DEPTH; j++)
        begin
            lb_new[j] = lb_reg[j-1];
        end
        for (int j = 0; j <= usrs_pkg::LB_DEPTH; j++)
        begin
            cont[j] = usrs_pkg::is_cont(lb_new[j]);
            lead[j] = usrs_pkg::lead_len(lb_new[j]);
        end
    end

    always_comb
    begin
        idx_c    = CW'(pos_reg);
        fin      = item.chunk_end;
        hex_next = (pos_reg == '0 && !rej_reg) ? cfg.hex_mode : hex_reg;
        rej_next = rej_reg || (idx_c >= CW'(MAX_CHUNK));

        // emit a deferred text row three bytes after its cut was chosen
        emit_pend = !rej_next && !hex_next && pv_reg && !fin &&
                    (idx_c >= CW'(pn_reg) + CW'(3));
        pv_mid    = pv_reg && !rej_next && !emit_pend;
        set_pend  = !rej_next && !hex_next && !pv_mid &&
                    (idx_c >= CW'(rb_reg) + CW'(TEXT_ROW_WIDTH));
        hex_emit  = !rej_next && hex_next && !fin &&
                    (idx_c + CW'(1) >= CW'(rb_reg) + CW'(HEX_ROW_WIDTH));

        // back the cut over trailing continuation bytes of an open sequence
        if (cont[0] && cont[1] && cont[2])
            kc = 2'd3;
        else if (cont[0] && cont[1])
            kc = 2'd2;
        else if (cont[0])
            kc = 2'd1;
        else
            kc = 2'd0;
        cut = (kc != 2'd0 && lead[kc] > {1'b0, kc}) ? pos_reg - POS_W'(kc) : pos_reg;

        pv_next  = set_pend ? 1'b1 : pv_mid;
        pb_next  = set_pend ? rb_reg : pb_reg;
        pc_next  = set_pend ? cut : pc_reg;
        pn_next  = set_pend ? pos_reg : pn_reg;
        rb_next  = set_pend ? cut : (hex_emit ? pos_reg + POS_W'(1) : rb_reg);
        pos_next = (pos_reg != POS_W'(MAX_CHUNK)) ? pos_reg + POS_W'(1) : pos_reg;
    end

    // chunk end: reject check and trimming of an incomplete tail
    always_comb
    begin
        size      = AW'(pos_reg) + AW'(1);
        bad       = rej_next || (cfg.chunk_offset > cfg.total_length) ||
                    (size > cfg.total_length - cfg.chunk_offset);
        tail_open = !hex_next && (cfg.chunk_offset + size < cfg.total_length);
        c0 = (pos_reg > POS_W'(0)) && cont[0];
        c1 = c0 && (pos_reg > POS_W'(1)) && cont[1];
        c2 = c1 && (pos_reg > POS_W'(2)) && cont[2];
        if (c2)
            k2 = 2'd3;
        else if (c1)
            k2 = 2'd2;
        else if (c0)
            k2 = 2'd1;
        else
            k2 = 2'd0;
        skip3 = (k2 == 2'd3) && (pos_reg > POS_W'(3)) && cont[3];
        trim  = tail_open && !skip3 &&
                (lead[k2] > usrs_pkg::SEQ_W'(k2) + usrs_pkg::SEQ_W'(1));
        kept  = trim ? pos_reg - POS_W'(k2) : pos_reg + POS_W'(1);
        split_two = !hex_next && pv_next && (pn_next < kept);
    end

    // first result slot
    always_comb
    begin
        base0 = rb_next;
        len0  = '0;
        last0 = 1'b0;
        if (fin)
        begin
            last0 = 1'b1;
            if (!hex_next && pv_next)
            begin
                base0 = pb_next;
                if (split_two)
                begin
                    len0  = pc_next - pb_next;
                    last0 = 1'b0;
                end
                else
                begin
                    len0 = kept - pb_next;
                end
            end
            else
            begin
                len0 = (kept > rb_next) ? kept - rb_next : '0;
            end
        end
        else if (hex_emit)
        begin
            base0 = rb_reg;
            len0  = pos_reg + POS_W'(1) - rb_reg;
        end
        else
        begin
            base0 = pb_reg;
            len0  = pc_reg - pb_reg;
        end

        next_off = cfg.chunk_offset + AW'(kept);

        res0.row_offset  = cfg.chunk_offset + AW'(base0);
        res0.row_length  = LW'(len0);
        res0.last_row    = last0;
        res0.status      = 1'b0;
        res0.next_offset = last0 ? next_off : '0;
        if (fin && bad)
        begin
            res0.row_offset  = '0;
            res0.row_length  = '0;
            res0.last_row    = 1'b1;
            res0.status      = 1'b1;
            res0.next_offset = '0;
        end

        res1.row_offset  = cfg.chunk_offset + AW'(pc_next);
        res1.row_length  = LW'(kept - pc_next);
        res1.last_row    = 1'b1;
        res1.status      = 1'b0;
        res1.next_offset = next_off;

        push.first  = fire && (fin || emit_pend || hex_emit);
        push.second = fire && fin && !bad && split_two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            rb_reg  <= '0;
            rej_reg <= 1'b0;
            hex_reg <= 1'b0;
            pv_reg  <= 1'b0;
        end
        else if (fire)
        begin
            hex_reg <= hex_next;
            if (fin)
            begin
                pos_reg <= '0;
                rb_reg  <= '0;
                rej_reg <= 1'b0;
                pv_reg  <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                rb_reg  <= rb_next;
                rej_reg <= rej_next;
                pv_reg  <= pv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            pn_reg <= pn_next;
            for (int j = 0; j < usrs_pkg::LB_DEPTH; j++)
            begin
                lb_reg[j] <= lb_new[j];
            end
        end
    end

endmodule

// ----- rtl/usrs_fifo.sv -----
// ============================================================================
// usrs_fifo: result queue
// Four-entry queue taking up to two results per cycle and handing out one
// while out_stall is low; reports room for a full two-result push.
// ============================================================================
module usrs_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  usrs_pkg::push_t       push,
    input  usrs_pkg::out_item_t   res0,
    input  usrs_pkg::out_item_t   res1,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_stall,
    output usrs_pkg::out_item_t   out_data
);

    localparam int PW = usrs_pkg::Q_PTR_W;
    localparam int NW = usrs_pkg::Q_CNT_W;

    usrs_pkg::out_item_t mem [0:usrs_pkg::Q_DEPTH-1];

    logic [PW-1:0] wr_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] rd_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          pop;
    logic [NW-1:0] push_n;

    always_comb
    begin
        pop      = out_valid && !out_stall;
        push_n   = NW'(push.first) + NW'(push.second);
        wr_next  = wr_reg + PW'(push_n);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + push_n - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_reg] <= res0;
        end
        if (push.second)
        begin
            mem[wr_reg + PW'(1)] <= res1;
        end
    end

    assign space     = cnt_reg <= NW'(usrs_pkg::Q_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem[rd_reg];

endmodule

// ----- verif/row_split_checker.sv -----
// ============================================================================
// row_split_checker: row prediction and comparison for the row splitter
// Watches the byte, row and configuration channels, keeps its own copy of the
// splitter state and register set, predicts the rows each accepted byte
// releases and compares every accepted row with the oldest one still due.
// ============================================================================
module row_split_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  usrs_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  usrs_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [usrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [usrs_pkg::ADDR_W-1:0]    cfg_data,
    output int                             fail_count,
    output int                             rows_pending
);

    localparam int unsigned LONGEST_CHUNK = 65536;
    localparam int unsigned TEXT_ROW      = 256;
    localparam int unsigned HEX_ROW       = 16;

    // register copies
    logic                        cfg_hex;
    logic [usrs_pkg::ADDR_W-1:0] cfg_base;
    logic [usrs_pkg::ADDR_W-1:0] cfg_total;

    // chunk state
    logic [31:0]       pos;
    logic [31:0]       row_start;
    logic [7:0]        recent [4];
    logic              dropped;
    logic              chunk_is_hex;
    logic              held_valid;
    logic [31:0]       held_start;
    logic [31:0]       held_cut;
    logic [31:0]       held_next;

    usrs_pkg::out_item_t rows_due [$];

    function automatic logic trail_byte(input logic [7:0] b);
        return (b & usrs_pkg::CONT_MASK) == usrs_pkg::CONT_TAG;
    endfunction

    // bytes a lead announces, 1 for anything that is not a valid lead
    function automatic int unsigned span_of(input logic [7:0] b);
        if (b >= usrs_pkg::LEAD4_LO && b <= usrs_pkg::LEAD4_HI) return 4;
        if (b >= usrs_pkg::LEAD3_LO && b <= usrs_pkg::LEAD3_HI) return 3;
        if (b >= usrs_pkg::LEAD2_LO && b <= usrs_pkg::LEAD2_HI) return 2;
        return 1;
    endfunction

    function automatic void queue_row(input logic [usrs_pkg::ADDR_W-1:0] off,
                                      input logic [31:0] len,
                                      input logic last, input logic st,
                                      input logic [usrs_pkg::ADDR_W-1:0] nxt);
        usrs_pkg::out_item_t row;
        row.row_offset  = off;
        row.row_length  = len[usrs_pkg::LEN_W-1:0];
        row.last_row    = last;
        row.status      = st;
        row.next_offset = nxt;
        rows_due = {rows_due, row};
    endfunction

    function automatic void clear_chunk();
        pos        = '0;
        row_start  = '0;
        dropped    = 1'b0;
        held_valid = 1'b0;
        held_start = '0;
        held_cut   = '0;
        held_next  = '0;
    endfunction

    task automatic predict_byte(input usrs_pkg::in_item_t item);
        logic [31:0]                 idx;
        logic [31:0]                 cut;
        logic [31:0]                 k;
        logic [31:0]                 kept;
        logic [usrs_pkg::ADDR_W-1:0] size;
        logic                        bad;
        logic                        fin;
        fin = item.chunk_end;
        idx = pos;
        if (idx == 0 && !dropped)
            chunk_is_hex = cfg_hex;
        recent[3] = recent[2];
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = item.data_byte;
        if (idx >= LONGEST_CHUNK)
        begin
            dropped    = 1'b1;
            held_valid = 1'b0;
        end
        if (!dropped)
        begin
            if (chunk_is_hex)
            begin
                if (!fin && idx + 1 - row_start >= HEX_ROW)
                begin
                    queue_row(cfg_base + row_start, idx + 1 - row_start, 1'b0, 1'b0, '0);
                    row_start = idx + 1;
                end
            end
            else
            begin
                // release the held row three bytes after its cut was chosen
                if (held_valid && !fin && idx >= held_next + 3)
                begin
                    queue_row(cfg_base + held_start, held_cut - held_start, 1'b0, 1'b0, '0);
                    held_valid = 1'b0;
                end
                if (!held_valid && idx >= row_start + TEXT_ROW)
                begin
                    k   = 0;
                    cut = idx;
                    while (k < 3 && trail_byte(recent[k]))
                        k++;
                    if (k > 0 && span_of(recent[k]) > k)
                        cut = idx - k;
                    held_valid = 1'b1;
                    held_start = row_start;
                    held_cut   = cut;
                    held_next  = idx;
                    row_start  = cut;
                end
            end
        end
        if (!fin)
        begin
            if (pos < LONGEST_CHUNK)
                pos++;
        end
        else
        begin
            size = usrs_pkg::ADDR_W'(idx) + 1;
            kept = idx + 1;
            bad  = dropped || cfg_base > cfg_total || size > cfg_total - cfg_base;
            if (bad)
                queue_row('0, 0, 1'b1, 1'b1, '0);
            else
            begin
                // a chunk that is not the last one drops an unfinished tail
                if (!chunk_is_hex && cfg_base + size < cfg_total)
                begin
                    k = 0;
                    while (k < 3 && idx - k > 0 && trail_byte(recent[k]))
                        k++;
                    if (!(k == 3 && idx - 3 > 0 && trail_byte(recent[3])))
                    begin
                        if (span_of(recent[k]) > k + 1)
                            kept = idx - k;
                    end
                end
                if (!chunk_is_hex && held_valid)
                begin
                    if (held_next < kept)
                    begin
                        queue_row(cfg_base + held_start, held_cut - held_start, 1'b0, 1'b0, '0);
                        queue_row(cfg_base + held_cut, kept - held_cut, 1'b1, 1'b0,
                                  cfg_base + kept);
                    end
                    else
                        queue_row(cfg_base + held_start, kept - held_start, 1'b1, 1'b0,
                                  cfg_base + kept);
                end
                else
                    queue_row(cfg_base + row_start, kept > row_start ? kept - row_start : 0,
                              1'b1, 1'b0, cfg_base + kept);
            end
            clear_chunk();
        end
    endtask

    task automatic check_row(input usrs_pkg::out_item_t got);
        usrs_pkg::out_item_t want;
        if (rows_due.size() == 0)
        begin
            if (fail_count < 10)
                $display("%0t: row with nothing due: off=%h len=%0d last=%b st=%b next=%h",
                         $time, got.row_offset, got.row_length, got.last_row, got.status,
                         got.next_offset);
            fail_count++;
        end
        else
        begin
            want = rows_due.pop_front();
            if (got !== want)
            begin
                if (fail_count < 10)
                begin
                    $display("%0t: row mismatch", $time);
                    $display("  expected off=%h len=%0d last=%b st=%b next=%h",
                             want.row_offset, want.row_length, want.last_row, want.status,
                             want.next_offset);
                    $display("  actual   off=%h len=%0d last=%b st=%b next=%h",
                             got.row_offset, got.row_length, got.last_row, got.status,
                             got.next_offset);
                end
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hex      = 1'b0;
            cfg_base     = '0;
            cfg_total    = '0;
            chunk_is_hex = 1'b0;
            for (int i = 0; i < 4; i++)
                recent[i] = '0;
            clear_chunk();
            rows_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_row(out_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    usrs_pkg::CFG_HEX_MODE:     cfg_hex   = cfg_data[0];
                    usrs_pkg::CFG_CHUNK_OFFSET: cfg_base  = cfg_data;
                    usrs_pkg::CFG_TOTAL_LENGTH: cfg_total = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_byte(in_data);
        end
        rows_pending = rows_due.size();
    end

endmodule

// ----- verif/testbench.sv -----
// ============================================================================
// testbench: top level for the UTF-8 safe row splitter
// Drives byte requests, configuration writes and row stalls with random
// idling, and gives the verdict from the failure count and pending row count
// of the row checker that sits beside the block.
// ============================================================================
module testbench;

    localparam logic [usrs_pkg::ADDR_W-1:0] ALL_ONES = '1;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    usrs_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    usrs_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [usrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [usrs_pkg::ADDR_W-1:0]    cfg_data = '0;

    int                   fail_count;
    int                   rows_pending;

    // bytes of the chunk being built, and running totals of what was sent
    logic [7:0]           chunk_bytes [$];
    int                   bytes_sent = 0;
    int                   chunks_sent = 0;

    always #5 clk = ~clk;

    utf8_safe_row_splitter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_split_checker row_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    // Idle length: mostly none or short, now and then a long gap.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Add one byte to the end of the chunk being built.
    function automatic void append_byte(input logic [7:0] b);
        chunk_bytes = {chunk_bytes, b};
    endfunction

    // Row side: free runs, some of them long, broken by stalls of random length.
    initial
    begin : row_stalls
        int run;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            run = gap_cycles();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // Offer one byte request and hold it until the block takes it. Keep valid
    // high across back-to-back requests; drop it only for a gap.
    task automatic push_byte(input logic [7:0] b, input logic fin, input logic idle);
        int gap;
        gap = idle ? gap_cycles() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, chunk_end: fin};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send the built chunk, marking its last byte, then clear it.
    task automatic send_chunk(input logic idle);
        for (int i = 0; i < chunk_bytes.size(); i++)
            push_byte(chunk_bytes[i], i == chunk_bytes.size() - 1, idle);
        bytes_sent += chunk_bytes.size();
        chunks_sent++;
        chunk_bytes.delete();
    endtask

    // Drop valid, wait for every predicted row to come out, then let the
    // pipeline settle for the extra cycles that the caller asks for.
    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [usrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [usrs_pkg::ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all three registers back to back; only bit 0 of the mode write
    // counts, so fill the rest with noise.
    task automatic load_settings(input logic hex, input logic [usrs_pkg::ADDR_W-1:0] base,
                                 input logic [usrs_pkg::ADDR_W-1:0] total);
        logic [usrs_pkg::ADDR_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(usrs_pkg::CFG_HEX_MODE, {junk[usrs_pkg::ADDR_W-1:1], hex});
        cfg_write(usrs_pkg::CFG_CHUNK_OFFSET, base);
        cfg_write(usrs_pkg::CFG_TOTAL_LENGTH, total);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_ascii(input int n);
        for (int i = 0; i < n; i++)
            append_byte(8'h41 + 8'(i % 26));
    endtask

    // Append n bytes of well-formed UTF-8 with some noise; the last sequence
    // is cut off where n runs out, which leaves unfinished tails.
    task automatic fill_utf8(input int n, input int noise_pct);
        int         stop;
        int         seq;
        logic [7:0] lead;
        stop = chunk_bytes.size() + n;
        while (chunk_bytes.size() < stop)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                append_byte(8'($urandom));
            else
            begin
                seq = $urandom_range(1, 4);
                case (seq)
                    1:       lead = 8'($urandom_range(0, 127));
                    2:       lead = 8'($urandom_range(usrs_pkg::LEAD2_LO, usrs_pkg::LEAD2_HI));
                    3:       lead = 8'($urandom_range(usrs_pkg::LEAD3_LO, usrs_pkg::LEAD3_HI));
                    default: lead = 8'($urandom_range(usrs_pkg::LEAD4_LO, usrs_pkg::LEAD4_HI));
                endcase
                append_byte(lead);
                for (int j = 1; j < seq && chunk_bytes.size() < stop; j++)
                    append_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
        end
    endtask

    initial
    begin : stimulus
        int                          len;
        int                          r;
        logic                        hex;
        logic                        idle;
        logic [usrs_pkg::ADDR_W-1:0] base;
        logic [usrs_pkg::ADDR_W-1:0] total;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: total length is zero, so any chunk is rejected.
        chunk_bytes = '{8'h41};
        send_chunk(1'b1);
        wait_idle(4);

        // Hex rows: exact row, one byte over, two rows plus one, extreme bytes.
        load_settings(1'b1, '0, ALL_ONES);
        repeat (16) append_byte(8'hff);
        send_chunk(1'b1);
        for (int i = 0; i < 17; i++)
            append_byte(i[0] ? 8'hff : 8'h00);
        send_chunk(1'b0);
        fill_utf8(33, 100);
        send_chunk(1'b1);
        wait_idle(4);

        // Final chunk of the value: keep an unfinished tail.
        load_settings(1'b0, 64'd100, 64'd103);
        chunk_bytes = '{8'h41, 8'he2, 8'h82};
        send_chunk(1'b1);
        wait_idle(4);

        // Chunks that are not the last: drop unfinished tails, including
        // chunks where nothing at all is kept.
        load_settings(1'b0, '0, ALL_ONES);
        chunk_bytes = '{8'h41, 8'he2, 8'h82};
        send_chunk(1'b1);
        chunk_bytes = '{8'hf0};
        send_chunk(1'b1);
        chunk_bytes = '{8'he2, 8'h82};
        send_chunk(1'b0);
        chunk_bytes = '{8'hf0, 8'h90, 8'h80};
        send_chunk(1'b1);
        chunk_bytes = '{8'hf0, 8'h90, 8'h80, 8'h80};
        send_chunk(1'b1);
        chunk_bytes = '{8'h80, 8'h80, 8'h80, 8'h80};
        send_chunk(1'b1);
        chunk_bytes = '{8'h41, 8'h80, 8'h80, 8'h80};
        send_chunk(1'b1);
        chunk_bytes = '{8'hc3};
        send_chunk(1'b1);
        chunk_bytes = '{8'h41, 8'hc0};
        send_chunk(1'b1);
        chunk_bytes = '{8'h41, 8'hf5};
        send_chunk(1'b1);
        chunk_bytes = '{8'h41, 8'hf4, 8'h8f};
        send_chunk(1'b1);

        // Text rows: a 3-byte sequence across the row edge moves the cut back.
        fill_ascii(300);
        chunk_bytes[254] = 8'he2;
        chunk_bytes[255] = 8'h82;
        chunk_bytes[256] = 8'hac;
        send_chunk(1'b1);
        // A dropped tail ends the chunk before the held row is released.
        fill_ascii(257);
        chunk_bytes[256] = 8'he2;
        send_chunk(1'b1);
        fill_ascii(258);
        chunk_bytes[256] = 8'he2;
        chunk_bytes[257] = 8'h82;
        send_chunk(1'b0);
        // A 4-byte sequence across the row edge.
        fill_ascii(260);
        chunk_bytes[253] = 8'hf0;
        chunk_bytes[254] = 8'h90;
        chunk_bytes[255] = 8'h80;
        chunk_bytes[256] = 8'h80;
        send_chunk(1'b1);
        wait_idle(4);

        // Past total after rows went out, and offset beyond total.
        load_settings(1'b1, 64'd10, 64'd30);
        fill_utf8(40, 50);
        send_chunk(1'b1);
        wait_idle(4);
        load_settings(1'b0, ALL_ONES, '0);
        chunk_bytes = '{8'h41, 8'h42};
        send_chunk(1'b1);
        wait_idle(4);

        // Offsets at the top of the range: fits exactly, then one byte over.
        load_settings(1'b1, ALL_ONES - 64'd20, ALL_ONES);
        fill_utf8(20, 30);
        send_chunk(1'b1);
        fill_utf8(21, 30);
        send_chunk(1'b1);
        wait_idle(4);
        load_settings(1'b0, ALL_ONES - 64'd5, ALL_ONES);
        chunk_bytes = '{8'he2, 8'h82, 8'hac, 8'h41, 8'hf0};
        send_chunk(1'b1);
        wait_idle(4);

        // Random chunks: mostly short, some spanning text rows. Reload the
        // registers between some chunks; run the rest back to back.
        bytes_sent  = 0;
        chunks_sent = 0;
        while (bytes_sent < 400 || chunks_sent < 12)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 16);
            else if (r < 90)
                len = $urandom_range(17, 64);
            else if (r < 97)
                len = $urandom_range(200, 320);
            else
                len = $urandom_range(321, 700);

            if (chunks_sent == 0 || $urandom_range(0, 99) < 35)
            begin
                hex = ($urandom_range(0, 2) == 0);
                r = $urandom_range(0, 99);
                if (r < 60)
                    base = 64'($urandom_range(0, 200000));
                else if (r < 80)
                    base = {$urandom, $urandom};
                else
                    base = ALL_ONES - 64'($urandom_range(0, 4000));
                r = $urandom_range(0, 99);
                if (r < 40)
                    total = base + len;
                else if (r < 80)
                    total = base + len + $urandom_range(1, 1000);
                else if (r < 90)
                    total = base + len - 1;
                else
                    total = {$urandom, $urandom};
                wait_idle(4);
                load_settings(hex, base, total);
            end

            if ($urandom_range(0, 3) == 0)
                fill_utf8(len, 100);
            else
                fill_utf8(len, $urandom_range(0, 10));
            idle = ($urandom_range(0, 4) != 0);
            send_chunk(idle);
        end

        wait_idle(8);
        if (fail_count == 0 && rows_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Stop a hung run well past the slowest correct one.
    initial
    begin : watchdog
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- utf8_safe_row_splitter_top.f -----
rtl/usrs_pkg.sv
rtl/usrs_cfg.sv
rtl/usrs_core.sv
rtl/usrs_fifo.sv
rtl/utf8_safe_row_splitter_top.sv
verif/row_split_checker.sv
verif/testbench.sv
